[rtl/arc_pkg.sv]
// Shared constants and types for the adaptive replacement cache unit.
`timescale 1ns / 1ps
package arc_pkg;
  localparam int CAPACITY = 64;
  localparam int POOL     = 2 * CAPACITY;
  localparam int IDX_W    = $clog2(POOL);
  localparam int CNT_W    = $clog2(POOL + 1);
  localparam int FRAC     = 8;
  localparam int P_W      = 15;
  localparam int KEY_W    = 32;
  localparam int CS_W     = 7;
  localparam int DIV_W    = CNT_W + FRAC;
  localparam int SUM_W    = DIV_W + 1;
  localparam int DCNT_W   = $clog2(DIV_W);

  typedef logic [1:0] list_t;
  localparam list_t L_T1 = 2'd0;
  localparam list_t L_T2 = 2'd1;
  localparam list_t L_B1 = 2'd2;
  localparam list_t L_B2 = 2'd3;

  typedef enum logic [2:0] {
    FOUND_NONE = 3'd0,
    FOUND_T1   = 3'd1,
    FOUND_T2   = 3'd2,
    FOUND_B1   = 3'd3,
    FOUND_B2   = 3'd4
  } found_t;
endpackage

[rtl/arc_cache_replacement_unit.sv]
// Adaptive replacement cache policy unit: list memories, scan, divider and sequencer.
// Flow: a scan of the whole pool, a serial divide on a ghost hit, then each list removal,
// move or insert in turn, and then the result strobe.
// Throughput: one item at a time; busy drops as the strobe rises; the receiver cannot stall.
// Reset: synchronous active-low; lists empty, p and counters zero, cache size CAPACITY.
`timescale 1ns / 1ps
module arc_cache_replacement_unit
  import arc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [KEY_W-1:0] in_page_key,
  output logic             out_valid,
  output logic             out_hit,
  output logic [2:0]       out_found_in,
  output logic             out_evicted_valid,
  output logic [KEY_W-1:0] out_evicted_key,
  output logic [P_W-1:0]   out_target_p,
  output logic [31:0]      out_hit_total,
  output logic [31:0]      out_miss_total,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CS_W-1:0]  cfg_cache_size
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_SCAN  = 10'b00_0000_0010,
    S_DIV   = 10'b00_0000_0100,
    S_ADAPT = 10'b00_0000_1000,
    S_DISP  = 10'b00_0001_0000,
    S_RD    = 10'b00_0010_0000,
    S_UNL   = 10'b00_0100_0000,
    S_PSH0  = 10'b00_1000_0000,
    S_PSH1  = 10'b01_0000_0000,
    S_DONE  = 10'b10_0000_0000
  } state_t;

  typedef enum logic [3:0] {
    PH_DROP  = 4'b0001,
    PH_REPL  = 4'b0010,
    PH_FINAL = 4'b0100,
    PH_END   = 4'b1000
  } phase_t;

  localparam logic [DIV_W-1:0] ONE = DIV_W'(1) << FRAC;

  state_t state_r, state_nxt;
  phase_t phase_r;

  logic [KEY_W-1:0] key_mem  [POOL];
  logic [IDX_W-1:0] next_mem [POOL];
  logic [IDX_W-1:0] prev_mem [POOL];
  list_t            tag_mem  [POOL];

  logic [KEY_W-1:0] key_rd_r;
  logic [IDX_W-1:0] next_rd_r, prev_rd_r;
  list_t            tag_rd_r;
  logic [IDX_W-1:0] rd_addr;

  logic [POOL-1:0]  valid_r;
  logic [IDX_W-1:0] front_r [4];
  logic [IDX_W-1:0] rear_r  [4];
  logic [CNT_W-1:0] cnt_r   [4];

  logic [KEY_W-1:0] key_r;
  logic [CS_W-1:0]  cs_r;
  logic [P_W-1:0]   p_r;
  logic [31:0]      hit_cnt_r, miss_cnt_r;

  logic [IDX_W:0]   scan_addr_r;
  logic             scan_vld_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic             match_r, free_vld_r;
  logic [IDX_W-1:0] match_idx_r, free_idx_r;
  list_t            match_list_r;
  found_t           found_r;

  logic [CNT_W-1:0]  rem_r, dvs_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DCNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]    div_sh, div_diff;
  logic              div_ge;

  logic  mc_drop_r, mc_drop_ev_r, mc_repl_r, repl_b2_r;
  list_t mc_drop_list_r;

  logic [IDX_W-1:0] op_e_r;
  list_t            op_src_r, op_dst_r;
  logic             op_push_r, op_ev_r, op_free_r, op_ins_r;

  logic             ev_vld_r;
  logic [KEY_W-1:0] ev_key_r;

  logic             out_valid_r, out_hit_r, out_ev_vld_r;
  logic [2:0]       out_found_r;
  logic [KEY_W-1:0] out_ev_key_r;
  logic [P_W-1:0]   out_p_r;
  logic [31:0]      out_hit_tot_r, out_miss_tot_r;

  logic             next_we, prev_we, tag_we, key_we, unl_go;
  logic [IDX_W-1:0] next_wa, next_wd, prev_wa, prev_wd;

  logic [CNT_W:0]   l1;
  logic [CNT_W+1:0] tot;
  logic [CNT_W+1:0] c_ext;
  logic [DIV_W-1:0] t1fix, p_ext, d_val;
  logic             repl_t1;
  logic [SUM_W-1:0] p_sum, c_fix;
  logic [CS_W-1:0]  cs_clamp;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  assign rd_addr = (state_r == S_SCAN) ? scan_addr_r[IDX_W-1:0] : op_e_r;

  always_comb begin
    if (cfg_cache_size == '0) begin
      cs_clamp = CS_W'(1);
    end else if (cfg_cache_size > CS_W'(CAPACITY)) begin
      cs_clamp = CS_W'(CAPACITY);
    end else begin
      cs_clamp = cfg_cache_size;
    end
  end

  assign div_sh   = {rem_r, quo_r[DIV_W-1]};
  assign div_ge   = (div_sh >= {1'b0, dvs_r});
  assign div_diff = div_sh - {1'b0, dvs_r};

  assign l1    = {1'b0, cnt_r[L_T1]} + {1'b0, cnt_r[L_B1]};
  assign tot   = {1'b0, l1} + {2'b00, cnt_r[L_T2]} + {2'b00, cnt_r[L_B2]};
  assign c_ext = (CNT_W+2)'(cs_r);

  assign t1fix   = {cnt_r[L_T1], FRAC'(0)};
  assign p_ext   = DIV_W'(p_r);
  assign repl_t1 = (cnt_r[L_T1] != '0) &&
                   ((t1fix > p_ext) || (repl_b2_r && (p_ext == t1fix)));

  assign d_val = (quo_r < ONE) ? ONE : quo_r;
  assign p_sum = SUM_W'(p_r) + SUM_W'(d_val);
  assign c_fix = SUM_W'(cs_r) << FRAC;

  assign unl_go = (cnt_r[op_src_r] != '0);

  always_comb begin
    next_we = 1'b0;
    next_wa = prev_rd_r;
    next_wd = next_rd_r;
    prev_we = 1'b0;
    prev_wa = next_rd_r;
    prev_wd = prev_rd_r;
    tag_we  = 1'b0;
    key_we  = 1'b0;
    case (state_r)
      S_UNL: begin
        next_we = unl_go && (op_e_r != front_r[op_src_r]);
        prev_we = unl_go && (op_e_r != rear_r[op_src_r]);
      end
      S_PSH0: begin
        next_we = 1'b1;
        next_wa = op_e_r;
        next_wd = front_r[op_dst_r];
        prev_we = 1'b1;
        prev_wa = op_e_r;
        prev_wd = op_e_r;
        tag_we  = 1'b1;
        key_we  = op_ins_r;
      end
      S_PSH1: begin
        prev_we = (cnt_r[op_dst_r] != '0);
        prev_wa = front_r[op_dst_r];
        prev_wd = op_e_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[op_e_r] <= key_r;
    end
    key_rd_r <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[op_e_r] <= op_dst_r;
    end
    tag_rd_r <= tag_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (start) state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_addr_r == (IDX_W+1)'(POOL) && !scan_vld_r) begin
          if (match_r && (match_list_r == L_B1 || match_list_r == L_B2)) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_DISP;
          end
        end
      end
      S_DIV:   if (div_cnt_r == DCNT_W'(DIV_W - 1)) state_nxt = S_ADAPT;
      S_ADAPT: state_nxt = S_DISP;
      S_DISP: begin
        case (phase_r)
          PH_DROP: begin
            if (mc_drop_r && cnt_r[mc_drop_list_r] != '0) state_nxt = S_RD;
          end
          PH_REPL: begin
            if (mc_repl_r && (repl_t1 || cnt_r[L_T2] != '0)) state_nxt = S_RD;
          end
          PH_FINAL: begin
            if (match_r) begin
              state_nxt = S_RD;
            end else if (free_vld_r) begin
              state_nxt = S_PSH0;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_RD:    state_nxt = S_UNL;
      S_UNL:   state_nxt = op_push_r ? S_PSH0 : S_DISP;
      S_PSH0:  state_nxt = S_PSH1;
      S_PSH1:  state_nxt = S_DISP;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_END;
      valid_r     <= '0;
      cs_r        <= CS_W'(CAPACITY);
      p_r         <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      scan_vld_r  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        front_r[i] <= '0;
        rear_r[i]  <= '0;
        cnt_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            cs_r    <= cs_clamp;
            valid_r <= '0;
            p_r     <= '0;
            for (int i = 0; i < 4; i++) begin
              front_r[i] <= '0;
              rear_r[i]  <= '0;
              cnt_r[i]   <= '0;
            end
          end
          if (start) begin
            key_r       <= in_page_key;
            scan_addr_r <= '0;
            scan_vld_r  <= 1'b0;
            match_r     <= 1'b0;
            free_vld_r  <= 1'b0;
            ev_vld_r    <= 1'b0;
            ev_key_r    <= '0;
          end
        end
        S_SCAN: begin
          if (scan_addr_r != (IDX_W+1)'(POOL)) begin
            scan_addr_r <= scan_addr_r + 1'b1;
            scan_idx_r  <= scan_addr_r[IDX_W-1:0];
            scan_vld_r  <= 1'b1;
          end else begin
            scan_vld_r <= 1'b0;
          end
          if (scan_vld_r) begin
            if (valid_r[scan_idx_r] && key_rd_r == key_r) begin
              match_r      <= 1'b1;
              match_idx_r  <= scan_idx_r;
              match_list_r <= tag_rd_r;
            end
            if (!valid_r[scan_idx_r] && !free_vld_r) begin
              free_vld_r <= 1'b1;
              free_idx_r <= scan_idx_r;
            end
          end
          if (scan_addr_r == (IDX_W+1)'(POOL) && !scan_vld_r) begin
            mc_drop_r    <= 1'b0;
            mc_drop_ev_r <= 1'b0;
            mc_repl_r    <= 1'b0;
            repl_b2_r    <= 1'b0;
            if (match_r && match_list_r == L_T1) begin
              found_r   <= FOUND_T1;
              hit_cnt_r <= hit_cnt_r + 1'b1;
              phase_r   <= PH_FINAL;
            end else if (match_r && match_list_r == L_T2) begin
              found_r   <= FOUND_T2;
              hit_cnt_r <= hit_cnt_r + 1'b1;
              phase_r   <= PH_FINAL;
            end else if (match_r) begin
              miss_cnt_r <= miss_cnt_r + 1'b1;
              mc_repl_r  <= 1'b1;
              phase_r    <= PH_REPL;
              rem_r      <= '0;
              div_cnt_r  <= '0;
              if (match_list_r == L_B1) begin
                found_r <= FOUND_B1;
                dvs_r   <= cnt_r[L_B1];
                quo_r   <= {cnt_r[L_B2], FRAC'(0)};
              end else begin
                found_r   <= FOUND_B2;
                repl_b2_r <= 1'b1;
                dvs_r     <= cnt_r[L_B2];
                quo_r     <= {cnt_r[L_B1], FRAC'(0)};
              end
            end else begin
              found_r    <= FOUND_NONE;
              miss_cnt_r <= miss_cnt_r + 1'b1;
              phase_r    <= PH_DROP;
              if ((CNT_W+2)'(l1) == c_ext) begin
                mc_drop_r <= 1'b1;
                if ((CNT_W+2)'(cnt_r[L_T1]) < c_ext) begin
                  mc_drop_list_r <= L_B1;
                  mc_repl_r      <= 1'b1;
                end else begin
                  mc_drop_list_r <= L_T1;
                  mc_drop_ev_r   <= 1'b1;
                end
              end else if ((CNT_W+2)'(l1) < c_ext && tot >= c_ext) begin
                mc_drop_r      <= (tot == {c_ext[CNT_W:0], 1'b0});
                mc_drop_list_r <= L_B2;
                mc_repl_r      <= 1'b1;
              end
            end
          end
        end
        S_DIV: begin
          rem_r     <= div_ge ? div_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
          quo_r     <= {quo_r[DIV_W-2:0], div_ge};
          div_cnt_r <= div_cnt_r + 1'b1;
        end
        S_ADAPT: begin
          if (!repl_b2_r) begin
            p_r <= (p_sum > c_fix) ? c_fix[P_W-1:0] : p_sum[P_W-1:0];
          end else begin
            p_r <= (p_ext > d_val) ? P_W'(p_ext - d_val) : '0;
          end
        end
        S_DISP: begin
          op_ev_r   <= 1'b0;
          op_free_r <= 1'b0;
          op_ins_r  <= 1'b0;
          op_push_r <= 1'b1;
          case (phase_r)
            PH_DROP: begin
              phase_r   <= PH_REPL;
              op_e_r    <= rear_r[mc_drop_list_r];
              op_src_r  <= mc_drop_list_r;
              op_push_r <= 1'b0;
              op_ev_r   <= mc_drop_ev_r;
              op_free_r <= 1'b1;
            end
            PH_REPL: begin
              phase_r <= PH_FINAL;
              op_ev_r <= 1'b1;
              if (repl_t1) begin
                op_e_r   <= rear_r[L_T1];
                op_src_r <= L_T1;
                op_dst_r <= L_B1;
              end else begin
                op_e_r   <= rear_r[L_T2];
                op_src_r <= L_T2;
                op_dst_r <= L_B2;
              end
            end
            PH_FINAL: begin
              phase_r <= PH_END;
              if (match_r) begin
                op_e_r   <= match_idx_r;
                op_src_r <= match_list_r;
                op_dst_r <= L_T2;
              end else begin
                op_e_r   <= free_idx_r;
                op_dst_r <= L_T1;
                op_ins_r <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_UNL: begin
          if (unl_go) begin
            if (op_e_r == front_r[op_src_r]) begin
              front_r[op_src_r] <= next_rd_r;
            end
            if (op_e_r == rear_r[op_src_r]) begin
              rear_r[op_src_r] <= prev_rd_r;
            end
            cnt_r[op_src_r] <= cnt_r[op_src_r] - 1'b1;
          end
          if (op_ev_r) begin
            ev_vld_r <= 1'b1;
            ev_key_r <= key_rd_r;
          end
          if (op_free_r) begin
            valid_r[op_e_r] <= 1'b0;
            if (!free_vld_r || op_e_r < free_idx_r) begin
              free_vld_r <= 1'b1;
              free_idx_r <= op_e_r;
            end
          end
        end
        S_PSH0: begin
          if (op_ins_r) begin
            valid_r[op_e_r] <= 1'b1;
          end
        end
        S_PSH1: begin
          if (cnt_r[op_dst_r] == '0) begin
            rear_r[op_dst_r] <= op_e_r;
          end
          front_r[op_dst_r] <= op_e_r;
          cnt_r[op_dst_r]   <= cnt_r[op_dst_r] + 1'b1;
        end
        S_DONE: begin
          out_valid_r    <= 1'b1;
          out_hit_r      <= (found_r == FOUND_T1) || (found_r == FOUND_T2);
          out_found_r    <= found_r;
          out_ev_vld_r   <= ev_vld_r;
          out_ev_key_r   <= ev_vld_r ? ev_key_r : '0;
          out_p_r        <= p_r;
          out_hit_tot_r  <= hit_cnt_r;
          out_miss_tot_r <= miss_cnt_r;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_found_in      = out_found_r;
  assign out_evicted_valid = out_ev_vld_r;
  assign out_evicted_key   = out_ev_key_r;
  assign out_target_p      = out_p_r;
  assign out_hit_total     = out_hit_tot_r;
  assign out_miss_total    = out_miss_tot_r;

endmodule

[rtl/arc_checker.sv]
// Port-level assertions for the adaptive replacement cache unit, bound to the unit module.
`timescale 1ns / 1ps
module arc_checker
  import arc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic             out_hit,
  input logic [2:0]       out_found_in,
  input logic             out_evicted_valid,
  input logic [KEY_W-1:0] out_evicted_key,
  input logic [P_W-1:0]   out_target_p
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but unit not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit == ((out_found_in == FOUND_T1) || (out_found_in == FOUND_T2))))
    else $error("hit flag disagrees with found code");

  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_evicted_valid |-> (out_evicted_key == '0))
    else $error("evicted key not zero without eviction");

  a_p_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_target_p <= P_W'(CAPACITY << FRAC)))
    else $error("target p above full cache");

endmodule

bind arc_cache_replacement_unit arc_checker u_arc_checker (.*);

[verif/arc_cache_replacement_unit_tb.sv]
// Self-checking testbench for the adaptive replacement cache unit: table, random refs, predictor.
`timescale 1ns / 1ps
module arc_cache_replacement_unit_tb;
  import arc_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 250;

  typedef struct packed {
    logic             hit;
    found_t           found;
    logic             ev_valid;
    logic [KEY_W-1:0] ev_key;
    logic [P_W-1:0]   p;
    logic [31:0]      hits;
    logic [31:0]      misses;
  } arc_res_t;

  typedef enum logic [1:0] {ROW_REF, ROW_REF_CHK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [KEY_W-1:0] value;
    arc_res_t         res;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [KEY_W-1:0] in_page_key = '0;
  logic             out_valid;
  logic             out_hit;
  logic [2:0]       out_found_in;
  logic             out_evicted_valid;
  logic [KEY_W-1:0] out_evicted_key;
  logic [P_W-1:0]   out_target_p;
  logic [31:0]      out_hit_total;
  logic [31:0]      out_miss_total;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CS_W-1:0]  cfg_cache_size = '0;

  arc_cache_replacement_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_page_key      (in_page_key),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_found_in     (out_found_in),
    .out_evicted_valid(out_evicted_valid),
    .out_evicted_key  (out_evicted_key),
    .out_target_p     (out_target_p),
    .out_hit_total    (out_hit_total),
    .out_miss_total   (out_miss_total),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_cache_size   (cfg_cache_size)
  );

  always #1 clk = ~clk;

  // Predictor state
  logic [KEY_W-1:0] pool_key [POOL];
  logic             pool_used[POOL];
  int               pool_next[POOL];
  int               pool_prev[POOL];
  int               lst_front[4];
  int               lst_rear [4];
  int               lst_cnt  [4];
  int               p_target;
  logic [31:0]      hit_cnt;
  logic [31:0]      miss_cnt;
  int               csize;

  arc_res_t expected_q[$];
  int       mismatches = 0;
  int       cycles = 0;
  int       idle_pct = 0;

  function automatic void flush_lists();
    for (int i = 0; i < POOL; i++) begin
      pool_key[i] = '0;
      pool_used[i] = 1'b0;
      pool_next[i] = 0;
      pool_prev[i] = 0;
    end
    for (int l = 0; l < 4; l++) begin
      lst_front[l] = 0;
      lst_rear[l] = 0;
      lst_cnt[l] = 0;
    end
    p_target = 0;
  endfunction

  function automatic void set_size(int v);
    csize = (v < 1) ? 1 : (v > CAPACITY) ? CAPACITY : v;
    flush_lists();
  endfunction

  function automatic int find_key(int l, logic [KEY_W-1:0] key);
    int idx;
    idx = lst_front[l];
    for (int i = 0; i < lst_cnt[l]; i++) begin
      if (pool_key[idx] == key) return idx;
      idx = pool_next[idx];
    end
    return -1;
  endfunction

  function automatic void unlink(int l, int e);
    if (lst_cnt[l] == 0) return;
    if (e == lst_front[l]) lst_front[l] = pool_next[e];
    else pool_next[pool_prev[e]] = pool_next[e];
    if (e == lst_rear[l]) lst_rear[l] = pool_prev[e];
    else pool_prev[pool_next[e]] = pool_prev[e];
    lst_cnt[l]--;
  endfunction

  function automatic void push_front(int l, int e);
    pool_prev[e] = e;
    pool_next[e] = lst_front[l];
    if (lst_cnt[l] == 0) lst_rear[l] = e;
    else pool_prev[lst_front[l]] = e;
    lst_front[l] = e;
    lst_cnt[l]++;
  endfunction

  function automatic void relink(int from, int to, int e);
    unlink(from, e);
    push_front(to, e);
  endfunction

  function automatic void drop_lru(int l, ref arc_res_t r, input bit report);
    int e;
    if (lst_cnt[l] == 0) return;
    e = lst_rear[l];
    if (report) begin
      r.ev_valid = 1'b1;
      r.ev_key = pool_key[e];
    end
    unlink(l, e);
    pool_used[e] = 1'b0;
  endfunction

  function automatic void demote(bit b2_hit, ref arc_res_t r);
    int t1fix;
    int e;
    t1fix = lst_cnt[L_T1] << FRAC;
    if (lst_cnt[L_T1] >= 1 && (t1fix > p_target || (b2_hit && p_target == t1fix))) begin
      e = lst_rear[L_T1];
      r.ev_valid = 1'b1;
      r.ev_key = pool_key[e];
      relink(L_T1, L_B1, e);
    end else if (lst_cnt[L_T2] != 0) begin
      e = lst_rear[L_T2];
      r.ev_valid = 1'b1;
      r.ev_key = pool_key[e];
      relink(L_T2, L_B2, e);
    end
  endfunction

  function automatic arc_res_t predict_ref(logic [KEY_W-1:0] key);
    arc_res_t r;
    int e;
    int d;
    int l1;
    int tot;
    int cfix;
    r = '0;
    r.found = FOUND_NONE;
    cfix = csize << FRAC;
    if ((e = find_key(L_T1, key)) >= 0) begin
      r.hit = 1'b1;
      r.found = FOUND_T1;
      hit_cnt++;
      relink(L_T1, L_T2, e);
    end else if ((e = find_key(L_T2, key)) >= 0) begin
      r.hit = 1'b1;
      r.found = FOUND_T2;
      hit_cnt++;
      relink(L_T2, L_T2, e);
    end else if ((e = find_key(L_B1, key)) >= 0) begin
      d = (lst_cnt[L_B2] << FRAC) / lst_cnt[L_B1];
      if (d < (1 << FRAC)) d = 1 << FRAC;
      r.found = FOUND_B1;
      miss_cnt++;
      p_target = (p_target + d > cfix) ? cfix : p_target + d;
      demote(1'b0, r);
      relink(L_B1, L_T2, e);
    end else if ((e = find_key(L_B2, key)) >= 0) begin
      d = (lst_cnt[L_B1] << FRAC) / lst_cnt[L_B2];
      if (d < (1 << FRAC)) d = 1 << FRAC;
      r.found = FOUND_B2;
      miss_cnt++;
      p_target = (p_target > d) ? p_target - d : 0;
      demote(1'b1, r);
      relink(L_B2, L_T2, e);
    end else begin
      miss_cnt++;
      l1 = lst_cnt[L_T1] + lst_cnt[L_B1];
      tot = l1 + lst_cnt[L_T2] + lst_cnt[L_B2];
      if (l1 == csize) begin
        if (lst_cnt[L_T1] < csize) begin
          drop_lru(L_B1, r, 1'b0);
          demote(1'b0, r);
        end else begin
          drop_lru(L_T1, r, 1'b1);
        end
      end else if (l1 < csize && tot >= csize) begin
        if (tot == 2 * csize) drop_lru(L_B2, r, 1'b0);
        demote(1'b0, r);
      end
      for (int i = 0; i < POOL; i++) begin
        if (!pool_used[i]) begin
          pool_used[i] = 1'b1;
          pool_key[i] = key;
          push_front(L_T1, i);
          break;
        end
      end
    end
    if (!r.ev_valid) r.ev_key = '0;
    r.p = P_W'(p_target);
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    return r;
  endfunction

  task automatic send_ref(logic [KEY_W-1:0] key, bit typed, arc_res_t typed_res);
    arc_res_t r;
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_page_key <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = predict_ref(key);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  task automatic write_size(logic [CS_W-1:0] v);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_cache_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    set_size(int'(v));
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    arc_res_t x;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        if (mismatches < 10) $display("unexpected item: key %h", out_evicted_key);
        mismatches++;
      end else begin
        x = expected_q.pop_front();
        if (out_hit !== x.hit || out_found_in !== 3'(x.found) ||
            out_evicted_valid !== x.ev_valid || out_evicted_key !== x.ev_key ||
            out_target_p !== x.p || out_hit_total !== x.hits ||
            out_miss_total !== x.misses) begin
          if (mismatches < 10) begin
            $display("mismatch: exp hit %0d in %0d ev %0d/%h p %0d h %0d m %0d",
                     x.hit, x.found, x.ev_valid, x.ev_key, x.p, x.hits, x.misses);
            $display("          got hit %0d in %0d ev %0d/%h p %0d h %0d m %0d",
                     out_hit, out_found_in, out_evicted_valid, out_evicted_key,
                     out_target_p, out_hit_total, out_miss_total);
          end
          mismatches++;
        end
      end
    end
  end

  initial begin
    row_t        tbl[$];
    int          sizes[3];
    int          wset;
    logic [31:0] base;
    logic [31:0] k;

    hit_cnt = '0;
    miss_cnt = '0;
    set_size(CAPACITY);

    tbl.push_back('{ROW_REF_CHK, 32'h0, '{1'b0, FOUND_NONE, 1'b0, 32'h0, 15'd0, 32'd0, 32'd1}});
    tbl.push_back('{ROW_REF_CHK, 32'h0, '{1'b1, FOUND_T1, 1'b0, 32'h0, 15'd0, 32'd1, 32'd1}});
    tbl.push_back('{ROW_REF_CHK, 32'hFFFF_FFFF,
                    '{1'b0, FOUND_NONE, 1'b0, 32'h0, 15'd0, 32'd1, 32'd2}});
    tbl.push_back('{ROW_REF_CHK, 32'h0, '{1'b1, FOUND_T2, 1'b0, 32'h0, 15'd0, 32'd2, 32'd2}});
    tbl.push_back('{ROW_REF_CHK, 32'hFFFF_FFFF,
                    '{1'b1, FOUND_T1, 1'b0, 32'h0, 15'd0, 32'd3, 32'd2}});
    tbl.push_back('{ROW_CFG, 32'd1, '0});
    tbl.push_back('{ROW_REF_CHK, 32'd5, '{1'b0, FOUND_NONE, 1'b0, 32'h0, 15'd0, 32'd3, 32'd3}});
    tbl.push_back('{ROW_REF_CHK, 32'd6, '{1'b0, FOUND_NONE, 1'b1, 32'd5, 15'd0, 32'd3, 32'd4}});
    tbl.push_back('{ROW_REF, 32'd5, '0});
    tbl.push_back('{ROW_CFG, 32'd2, '0});
    tbl.push_back('{ROW_REF, 32'd1, '0});
    tbl.push_back('{ROW_REF, 32'd2, '0});
    tbl.push_back('{ROW_REF, 32'd3, '0});
    tbl.push_back('{ROW_REF, 32'd2, '0});
    tbl.push_back('{ROW_REF, 32'd4, '0});
    tbl.push_back('{ROW_REF, 32'd3, '0});
    tbl.push_back('{ROW_REF, 32'd5, '0});
    tbl.push_back('{ROW_REF, 32'd2, '0});
    tbl.push_back('{ROW_REF, 32'd6, '0});
    tbl.push_back('{ROW_REF, 32'd4, '0});
    tbl.push_back('{ROW_REF, 32'd1, '0});
    tbl.push_back('{ROW_CFG, 32'd0, '0});
    tbl.push_back('{ROW_REF, 32'h8000_0000, '0});
    tbl.push_back('{ROW_CFG, 32'd127, '0});
    tbl.push_back('{ROW_REF, 32'h7FFF_FFFF, '0});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tbl[i]) begin
      if (tbl[i].kind == ROW_CFG) write_size(CS_W'(tbl[i].value));
      else send_ref(tbl[i].value, tbl[i].kind == ROW_REF_CHK, tbl[i].res);
    end

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : (ph == 1) ? 82 : 0;
      sizes[0] = 1;
      sizes[1] = $urandom_range(2, 20);
      sizes[2] = (ph == 1) ? 64 : $urandom_range(1, 127);
      for (int s = 0; s < 3; s++) begin
        write_size(CS_W'(sizes[s]));
        wset = 2 * csize + 4;
        base = $urandom();
        for (int n = 0; n < 160; n++) begin
          if ($urandom_range(0, 9) == 0) k = $urandom();
          else if ($urandom_range(0, 2) == 0) k = base + $urandom_range(0, csize / 2 + 1);
          else k = base + $urandom_range(0, wset);
          send_ref(k, 1'b0, '0);
        end
      end
    end

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/arc_pkg.sv
rtl/arc_cache_replacement_unit.sv
rtl/arc_checker.sv
verif/arc_cache_replacement_unit_tb.sv
